>>> rtl/slse_pkg.sv
// ----------------------------------------------------------------------------
// Slew-limited speed estimator package
// Widths, reset values and register indexes shared by the estimator files.
// ----------------------------------------------------------------------------
package slse_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned POS_W      = 32;
    localparam int unsigned SPEED_W    = 32;
    localparam int unsigned DIFF_W     = POS_W + 1;
    localparam int unsigned DIVIDEND_W = 42;
    localparam int unsigned DIVISOR_W  = TIME_W;
    localparam int unsigned THR_W      = 31;
    localparam int unsigned LIMIT_W    = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 31;

    localparam logic [THR_W-1:0]     THR_RESET   = 31'd655360;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 8'd200;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE   = 2'd1;

endpackage

>>> rtl/slse_div.sv
// ----------------------------------------------------------------------------
// Slew-limited speed estimator serial divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slse_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [slse_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [slse_pkg::DIVISOR_W-1:0]      i_divisor,
    output logic                                o_done,
    output logic [slse_pkg::DIVIDEND_W-1:0]     o_quotient
);

    localparam int unsigned CNT_W = $clog2(slse_pkg::DIVIDEND_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(slse_pkg::DIVIDEND_W - 1);

    logic                                r_busy;
    logic                                r_done;
    logic [CNT_W-1:0]                    r_cnt;
    logic [slse_pkg::DIVIDEND_W-1:0]     r_num;
    logic [slse_pkg::DIVISOR_W:0]        r_rem;
    logic [slse_pkg::DIVISOR_W-1:0]      r_div;
    logic [slse_pkg::DIVISOR_W:0]        n_shift;
    logic                                n_fit;

    assign n_shift = {r_rem[slse_pkg::DIVISOR_W-1:0], r_num[slse_pkg::DIVIDEND_W-1]};
    assign n_fit   = (n_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_LAST;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[slse_pkg::DIVIDEND_W-2:0], n_fit};
            r_rem <= n_fit ? (n_shift - {1'b0, r_div}) : n_shift;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;

endmodule

>>> rtl/slew_limited_speed_estimator_unit.sv
// ----------------------------------------------------------------------------
// Slew-limited speed estimator
// Finite-difference speed from timestamped positions, saturated, slew
// limited and forced to zero when timestamps go stale.
// ----------------------------------------------------------------------------
// Sequence: a new timestamp passes ST_ABS, ST_MUL_A, ST_MUL_B, ST_LOAD, the
// 42-step serial divider in ST_DIV, ST_SAT, ST_DELTA, ST_STEP and ST_FINISH;
// a repeated timestamp goes straight to ST_FINISH. One item at a time: no new
// item is taken until ST_IDLE, and ST_FINISH waits while a result is stalled.
// Reset: synchronous active-low reset clears the state and loads the
// register defaults of 10.0 for the slew threshold and 200 for the limit.
// ----------------------------------------------------------------------------
module slew_limited_speed_estimator_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [slse_pkg::TIME_W-1:0]             i_timestamp_ms,
    input  logic signed [slse_pkg::POS_W-1:0]       i_position,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [slse_pkg::SPEED_W-1:0]     o_speed_out,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [slse_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [slse_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABS,
        ST_MUL_A,
        ST_MUL_B,
        ST_LOAD,
        ST_DIV,
        ST_SAT,
        ST_DELTA,
        ST_STEP,
        ST_FINISH
    } t_state;

    localparam int unsigned DW  = slse_pkg::DIVIDEND_W;
    localparam int unsigned SW  = slse_pkg::SPEED_W;
    localparam int unsigned LW  = slse_pkg::LIMIT_W;
    localparam int unsigned CW  = SW + 2;

    t_state                              r_state;
    logic [slse_pkg::THR_W-1:0]          r_thr;
    logic [LW-1:0]                       r_limit;
    logic [slse_pkg::TIME_W-1:0]         r_prev_time;
    logic signed [slse_pkg::POS_W-1:0]   r_prev_pos;
    logic signed [SW-1:0]                r_filt;
    logic [LW-1:0]                       r_stale;
    logic                                r_new;
    logic [slse_pkg::TIME_W-1:0]         r_dt;
    logic [slse_pkg::DIFF_W-1:0]         r_diff;
    logic                                r_neg;
    logic [slse_pkg::DIFF_W-1:0]         r_mag;
    logic [DW-1:0]                       r_acc;
    logic signed [SW-1:0]                r_raw;
    logic signed [CW-1:0]                r_delta;
    logic                                r_out_valid;
    logic signed [SW-1:0]                r_speed;

    logic                                div_start;
    logic                                div_done;
    logic [DW-1:0]                       div_quot;
    logic [LW-1:0]                       n_stale;
    logic                                n_big;
    logic signed [CW-1:0]                n_thr;
    logic                                n_accept;

    assign n_accept  = i_valid && (r_state == ST_IDLE);
    assign div_start = (r_state == ST_LOAD);
    assign n_big     = (div_quot[DW-1:SW-1] != '0);
    assign n_thr     = $signed({3'b000, r_thr});

    always_comb begin
        if (r_new) begin
            n_stale = '0;
        end else if (r_stale == {LW{1'b1}}) begin
            n_stale = r_stale;
        end else begin
            n_stale = r_stale + 1'b1;
        end
    end

    slse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_dt),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_thr       <= slse_pkg::THR_RESET;
            r_limit     <= slse_pkg::LIMIT_RESET;
            r_prev_time <= '0;
            r_prev_pos  <= '0;
            r_filt      <= '0;
            r_stale     <= '0;
            r_new       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    slse_pkg::CFG_SLEW:  r_thr   <= i_cfg_data[slse_pkg::THR_W-1:0];
                    slse_pkg::CFG_STALE: r_limit <= i_cfg_data[LW-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        r_new  <= (i_timestamp_ms != r_prev_time);
                        r_dt   <= i_timestamp_ms - r_prev_time;
                        r_diff <= {i_position[SW-1], i_position}
                                - {r_prev_pos[SW-1], r_prev_pos};
                        if (i_timestamp_ms != r_prev_time) begin
                            r_prev_time <= i_timestamp_ms;
                            r_prev_pos  <= i_position;
                            r_state     <= ST_ABS;
                        end else begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_ABS: begin
                    r_neg   <= r_diff[slse_pkg::DIFF_W-1];
                    r_mag   <= r_diff[slse_pkg::DIFF_W-1] ? (~r_diff + 1'b1) : r_diff;
                    r_state <= ST_MUL_A;
                end
                ST_MUL_A: begin
                    r_acc   <= (DW'(r_mag) << 10) - (DW'(r_mag) << 4);
                    r_state <= ST_MUL_B;
                end
                ST_MUL_B: begin
                    r_acc   <= r_acc - (DW'(r_mag) << 3);
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    if (n_big) begin
                        r_raw <= r_neg ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
                    end else if (r_neg) begin
                        r_raw <= -$signed(div_quot[SW-1:0]);
                    end else begin
                        r_raw <= $signed(div_quot[SW-1:0]);
                    end
                    r_state <= ST_DELTA;
                end
                ST_DELTA: begin
                    r_delta <= CW'(r_raw) - CW'(r_filt);
                    r_state <= ST_STEP;
                end
                ST_STEP: begin
                    if (r_delta < -n_thr) begin
                        r_filt <= r_filt - $signed({1'b0, r_thr});
                    end else if (r_delta > n_thr) begin
                        r_filt <= r_filt + $signed({1'b0, r_thr});
                    end else begin
                        r_filt <= r_raw;
                    end
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!r_out_valid || !i_stall) begin
                        r_stale     <= n_stale;
                        r_out_valid <= 1'b1;
                        if (n_stale > r_limit) begin
                            r_filt  <= '0;
                            r_speed <= '0;
                        end else begin
                            r_speed <= r_filt;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_speed_out = r_speed;
    assign o_cfg_ready = 1'b1;

endmodule
